### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared constants, types and fixed point helpers for the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int DT_W      = 16;
   localparam int LIMIT_W   = 31;
   localparam int MODE_W    = 2;
   localparam int INDEX_W   = 3;
   localparam int NUM_MAG_W = 34;
   localparam int DVD_W     = NUM_MAG_W + FRAC_W;

   localparam logic [INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_OUT_MIN     = 3'd3;
   localparam logic [INDEX_W-1:0] REG_OUT_MAX     = 3'd4;
   localparam logic [INDEX_W-1:0] REG_INTEG_LIMIT = 3'd5;
   localparam logic [INDEX_W-1:0] REG_DERIV_MODE  = 3'd6;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ERR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BUMP = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [NUM_MAG_W-1:0] num;
      logic [DATA_W-1:0]    den;
   } div_req_type;

   localparam logic signed [63:0] MAX_V = 64'sd2147483647;
   localparam logic signed [63:0] MIN_V = -64'sd2147483648;

   function automatic data_type sat64(input logic signed [63:0] v);
      data_type r;
      if (v > MAX_V) begin
         r = data_type'(MAX_V);
      end else if (v < MIN_V) begin
         r = data_type'(MIN_V);
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Drops the fraction bits of a product, rounding toward zero, then saturates.
   function automatic data_type mul_shift(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + (p[63] ? 64'sd65535 : 64'sd0)) >>> FRAC_W;
      return sat64(t);
   endfunction

endpackage

### rtl/pidc_div.sv
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring bit-serial divider giving (num * 2^16) / den, truncated toward
// zero and saturated to a signed data word. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pidc_pkg::div_req_type req,
   output logic                  done,
   output pidc_pkg::data_type    quotient
);
   import pidc_pkg::*;

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff;
   logic              neg_ff;
   logic [5:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         dvd_in = {req.num, {FRAC_W{1'b0}}};
         quo_in = '0;
         cnt_in = 6'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DATA_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DATA_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      if (req.start) begin
         den_ff <= req.den;
         neg_ff <= req.neg;
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (quo_ff > DVD_W'(64'd2147483648)) begin
            quotient = data_type'(MIN_V);
         end else begin
            quotient = data_type'(-quo_ff[DATA_W-1:0]);
         end
      end else if (quo_ff > DVD_W'(64'd2147483647)) begin
         quotient = data_type'(MAX_V);
      end else begin
         quotient = quo_ff[DATA_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

### rtl/pid_controller_antiwindup_top.sv
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Fixed point Q16.16 PID controller built around one shared multiplier and a
// bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: the request channel takes one word holding the measured value, the
// setpoint and the time step. The response channel returns one word with the
// clamped drive value. Gains, limits and the derivative mode are written
// through the csr port; the user must write them only while the block is
// idle, as the block itself does not enforce that. Each division, an integral
// trim or a derivative quotient, runs bit-serially in the shared divider; at
// most two run per word. One word is in work at a time; req_ready is high
// only while the sequencer is idle.
// Reset clears the configuration registers, the integral sum and the sample history.
// When the receiver stalls, the response stays in its output register and no
// new request is taken until it has been accepted.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_measured,
   input  logic signed [31:0]             req_target,
   input  logic [15:0]                    req_step_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_drive,
   input  logic                           csr_wr_en,
   input  logic [pidc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [31:0]                    csr_wdata
);
   import pidc_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MUL_P   = 4'd1;
   localparam logic [3:0] ST_MUL_E   = 4'd2;
   localparam logic [3:0] ST_SUM     = 4'd3;
   localparam logic [3:0] ST_MUL_I   = 4'd4;
   localparam logic [3:0] ST_TRIM_HI = 4'd5;
   localparam logic [3:0] ST_TRIM_LO = 4'd6;
   localparam logic [3:0] ST_DERIV   = 4'd7;
   localparam logic [3:0] ST_DIV     = 4'd8;
   localparam logic [3:0] ST_MUL_D   = 4'd9;
   localparam logic [3:0] ST_ADD     = 4'd10;
   localparam logic [3:0] ST_OUT     = 4'd11;

   data_type           prop_gain_ff, integ_gain_ff, deriv_gain_ff, out_min_ff, out_max_ff;
   logic [LIMIT_W-1:0] integ_limit_ff;
   logic [MODE_W-1:0]  deriv_mode_ff;

   logic [3:0]         state_ff, ret_ff;
   logic               dest_diff_ff;
   data_type           meas_ff, err_ff, p_ff, i_ff, sum_ff, diff_ff, drive_ff;
   data_type           prev_a_ff, prev_b_ff;
   logic [1:0]         hist_ff;
   logic [DT_W-1:0]    dt_ff;
   logic signed [63:0] prod_ff;
   logic               rsp_valid_ff;

   data_type           mul_a, mul_b;
   data_type           prod_q;
   div_req_type        div_req;
   logic               div_done;
   data_type           div_q;

   logic signed [32:0] err_wide, sum_wide, room_hi, room_lo;
   data_type           sum_sat, sum_clamped, lim_pos, lim_neg;
   logic signed [34:0] num_err, num_bump;
   logic signed [33:0] drive_wide;
   data_type           trim_hi, trim_lo;

   assign prod_q   = mul_shift(prod_ff);
   assign err_wide = 33'(req_target) - 33'(req_measured);
   assign sum_wide = 33'(sum_ff) + 33'(prod_q);
   assign lim_pos  = {1'b0, integ_limit_ff};
   assign lim_neg  = -lim_pos;
   assign room_hi  = 33'(out_max_ff) - 33'(p_ff);
   assign room_lo  = 33'(out_min_ff) - 33'(p_ff);
   assign trim_hi  = room_hi[DATA_W-1:0];
   assign trim_lo  = room_lo[DATA_W-1:0];
   assign num_err  = 35'(err_ff) - 35'(prev_a_ff);
   assign num_bump = 35'(meas_ff) - 35'(prev_a_ff) - 35'(prev_a_ff) + 35'(prev_b_ff);
   assign drive_wide = 34'(p_ff) + 34'(i_ff) + 34'(prod_q);

   always_comb begin
      sum_sat = sat64(64'(sum_wide));
      sum_clamped = sum_sat;
      if (integ_limit_ff != '0) begin
         if (sum_sat < lim_neg) begin
            sum_clamped = lim_neg;
         end else if (sum_sat > lim_pos) begin
            sum_clamped = lim_pos;
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = prop_gain_ff;
            mul_b = err_ff;
         end
         ST_MUL_E: begin
            mul_a = err_ff;
            mul_b = {{(DATA_W-DT_W){1'b0}}, dt_ff};
         end
         ST_MUL_I: begin
            mul_a = integ_gain_ff;
            mul_b = sum_ff;
         end
         default: begin
            mul_a = deriv_gain_ff;
            mul_b = diff_ff;
         end
      endcase
   end

   always_comb begin
      div_req       = '0;
      div_req.start = 1'b0;
      unique case (state_ff)
         ST_TRIM_HI: begin
            div_req.start = (p_ff < out_max_ff) && (p_ff > 0) && (prod_q > 0)
                            && (33'(prod_q) > room_hi) && (integ_gain_ff != 0);
            div_req.neg   = integ_gain_ff < 0;
            div_req.num   = NUM_MAG_W'(trim_hi);
            div_req.den   = integ_gain_ff[DATA_W-1] ? -integ_gain_ff : integ_gain_ff;
         end
         ST_TRIM_LO: begin
            div_req.start = (p_ff > out_min_ff) && (p_ff < 0) && (i_ff < 0)
                            && (33'(i_ff) < room_lo) && (integ_gain_ff != 0);
            div_req.neg   = integ_gain_ff >= 0;
            div_req.num   = NUM_MAG_W'(-33'(trim_lo));
            div_req.den   = integ_gain_ff[DATA_W-1] ? -integ_gain_ff : integ_gain_ff;
         end
         ST_DERIV: begin
            div_req.den = {{(DATA_W-DT_W){1'b0}}, dt_ff};
            if (deriv_mode_ff == MODE_ERR) begin
               div_req.start = (hist_ff == 2'd1) && (dt_ff != '0);
               div_req.neg   = num_err < 0;
               div_req.num   = num_err[34] ? NUM_MAG_W'(-num_err) : NUM_MAG_W'(num_err);
            end else begin
               div_req.start = (deriv_mode_ff == MODE_BUMP) && (hist_ff == 2'd2)
                               && (dt_ff != '0);
               div_req.neg   = num_bump < 0;
               div_req.num   = num_bump[34] ? NUM_MAG_W'(-num_bump) : NUM_MAG_W'(num_bump);
            end
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   pidc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         out_min_ff     <= '0;
         out_max_ff     <= '0;
         integ_limit_ff <= '0;
         deriv_mode_ff  <= MODE_NONE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
            REG_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
            REG_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata;
            REG_OUT_MIN:     out_min_ff     <= csr_wdata;
            REG_OUT_MAX:     out_max_ff     <= csr_wdata;
            REG_INTEG_LIMIT: integ_limit_ff <= csr_wdata[LIMIT_W-1:0];
            REG_DERIV_MODE:  deriv_mode_ff  <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         hist_ff      <= '0;
         ret_ff       <= ST_IDLE;
         dest_diff_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  meas_ff  <= req_measured;
                  dt_ff    <= req_step_time;
                  err_ff   <= sat64(64'(err_wide));
                  state_ff <= ST_MUL_P;
               end
            end
            ST_MUL_P: state_ff <= ST_MUL_E;
            ST_MUL_E: begin
               p_ff     <= prod_q;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= sum_clamped;
               state_ff <= ST_MUL_I;
            end
            ST_MUL_I: state_ff <= ST_TRIM_HI;
            ST_TRIM_HI: begin
               state_ff <= ST_TRIM_LO;
               if (p_ff >= out_max_ff) begin
                  i_ff   <= '0;
                  sum_ff <= '0;
               end else if ((p_ff > 0) && (prod_q > 0) && (33'(prod_q) > room_hi)) begin
                  i_ff <= trim_hi;
                  if (integ_gain_ff != 0) begin
                     dest_diff_ff <= 1'b0;
                     ret_ff       <= ST_TRIM_LO;
                     state_ff     <= ST_DIV;
                  end else begin
                     sum_ff <= '0;
                  end
               end else begin
                  i_ff <= prod_q;
               end
            end
            ST_TRIM_LO: begin
               state_ff <= ST_DERIV;
               if (p_ff <= out_min_ff) begin
                  i_ff   <= '0;
                  sum_ff <= '0;
               end else if ((p_ff < 0) && (i_ff < 0) && (33'(i_ff) < room_lo)) begin
                  i_ff <= trim_lo;
                  if (integ_gain_ff != 0) begin
                     dest_diff_ff <= 1'b0;
                     ret_ff       <= ST_DERIV;
                     state_ff     <= ST_DIV;
                  end else begin
                     sum_ff <= '0;
                  end
               end
            end
            ST_DERIV: begin
               diff_ff  <= '0;
               state_ff <= div_req.start ? ST_DIV : ST_MUL_D;
               dest_diff_ff <= 1'b1;
               ret_ff   <= ST_MUL_D;
               if (deriv_mode_ff == MODE_ERR) begin
                  prev_a_ff <= err_ff;
                  if (hist_ff == 2'd0) begin
                     hist_ff <= 2'd1;
                  end
               end else if (deriv_mode_ff == MODE_BUMP) begin
                  prev_b_ff <= prev_a_ff;
                  prev_a_ff <= meas_ff;
                  if (hist_ff != 2'd2) begin
                     hist_ff <= hist_ff + 2'd1;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (dest_diff_ff) begin
                     diff_ff <= div_q;
                  end else begin
                     sum_ff <= div_q;
                  end
                  state_ff <= ret_ff;
               end
            end
            ST_MUL_D: state_ff <= ST_ADD;
            ST_ADD: begin
               // With crossed limits the lower clamp is tested first, so the
               // lower limit always wins.
               if ((drive_wide < 34'(out_min_ff)) || (out_max_ff < out_min_ff)) begin
                  drive_ff <= out_min_ff;
               end else if (drive_wide > 34'(out_max_ff)) begin
                  drive_ff <= out_max_ff;
               end else begin
                  drive_ff <= drive_wide[DATA_W-1:0];
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

endmodule

### rtl/pidc_checker.sv
// ----------------------------------------------------------------------------
// PID controller port checker
// Checks the request and response ports of the PID controller over time.
// ----------------------------------------------------------------------------
module pidc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_drive
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("Response word changed while stalled.");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Request taken while a response is pending.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("Block not busy after accepting a request.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("Block not idle after reset.");

endmodule

bind pid_controller_antiwindup_top pidc_checker u_pidc_checker (.*);
